// File: rtl/core/sitda_pkg.sv
`timescale 1ns / 1ps
// Shared constants and controller/datapath interface structs for the
// signed integer to decimal ASCII converter. No dependencies.
package sitda_pkg;

  localparam int VALUE_W     = 64;
  localparam int PAD_W       = 6;
  localparam int CHAR_W      = 6;
  localparam int DIGITS      = 20;  // BCD digits for a 64-bit magnitude
  localparam int NDIG_W      = 5;
  localparam int BCD_W       = 4 * DIGITS;
  localparam int BIT_CNT_W   = 6;
  localparam int MAX_LEN_DEF = 32;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic conv_step;
    logic norm_step;
    logic prep;
    logic emit_step;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic conv_last;
    logic norm_done;
    logic emit_last;
  } sts_t;

endpackage

// File: rtl/core/sitda_dp.sv
`timescale 1ns / 1ps
// Datapath: magnitude capture, shift-add-3 binary to BCD, leading-zero
// strip, and character output register. Depends on sitda_pkg.
module sitda_dp import sitda_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [PAD_W-1:0]         in_pad_width,
  output logic                     out_valid,
  output logic [CHAR_W-1:0]        out_char_code,
  output logic                     out_last
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int CMP_W = (LEN_W > PAD_W) ? LEN_W : PAD_W;
  localparam logic [CMP_W-1:0] MAX_LEN_C = CMP_W'(MAX_LEN);

  logic [VALUE_W-1:0]   mag_r, mag_nxt;
  logic                 neg_r, neg_nxt;
  logic [LEN_W-1:0]     pad_r, pad_nxt;
  logic [BCD_W-1:0]     bcd_r, bcd_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [NDIG_W-1:0]    ndig_r, ndig_nxt;
  logic [LEN_W-1:0]     zeros_r, zeros_nxt;
  logic                 sign_pend_r, sign_pend_nxt;
  logic                 valid_r, valid_nxt;
  logic [CHAR_W-1:0]    char_r, char_nxt;
  logic                 last_r, last_nxt;

  logic [BCD_W-1:0]     bcd_adj;
  logic [CMP_W-1:0]     pad_ext;
  logic [LEN_W-1:0]     natural_len;
  logic                 emit_last;

  // add 3 to every digit at or above 5 before the shift
  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4];
      end
    end
  end

  assign pad_ext     = CMP_W'(in_pad_width);
  assign natural_len = LEN_W'(ndig_r) + LEN_W'(neg_r);
  assign emit_last   = !sign_pend_r && (zeros_r == '0) && (ndig_r == NDIG_W'(1));

  assign sts.conv_last = (bit_cnt_r == {BIT_CNT_W{1'b1}});
  assign sts.norm_done = (bcd_r[BCD_W-1 -: 4] != 4'd0) || (ndig_r == NDIG_W'(1));
  assign sts.emit_last = emit_last;

  always_comb begin
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    pad_nxt       = pad_r;
    bcd_nxt       = bcd_r;
    bit_cnt_nxt   = bit_cnt_r;
    ndig_nxt      = ndig_r;
    zeros_nxt     = zeros_r;
    sign_pend_nxt = sign_pend_r;
    valid_nxt     = 1'b0;
    char_nxt      = char_r;
    last_nxt      = last_r;
    priority if (cmd.load) begin
      neg_nxt     = in_value[VALUE_W-1];
      mag_nxt     = in_value[VALUE_W-1] ? (~$unsigned(in_value) + 64'd1) : $unsigned(in_value);
      pad_nxt     = (pad_ext > MAX_LEN_C) ? LEN_W'(MAX_LEN) : LEN_W'(pad_ext);
      bcd_nxt     = '0;
      bit_cnt_nxt = '0;
      ndig_nxt    = NDIG_W'(DIGITS);
    end else if (cmd.conv_step) begin
      bcd_nxt     = {bcd_adj[BCD_W-2:0], mag_r[VALUE_W-1]};
      mag_nxt     = {mag_r[VALUE_W-2:0], 1'b0};
      bit_cnt_nxt = bit_cnt_r + BIT_CNT_W'(1);
    end else if (cmd.norm_step) begin
      if (!sts.norm_done) begin
        bcd_nxt  = {bcd_r[BCD_W-5:0], 4'd0};
        ndig_nxt = ndig_r - NDIG_W'(1);
      end
    end else if (cmd.prep) begin
      zeros_nxt     = (pad_r > natural_len) ? (pad_r - natural_len) : '0;
      sign_pend_nxt = neg_r;
    end else if (cmd.emit_step) begin
      valid_nxt = 1'b1;
      last_nxt  = emit_last;
      if (sign_pend_r) begin
        char_nxt      = ASCII_MINUS;
        sign_pend_nxt = 1'b0;
      end else if (zeros_r != '0) begin
        char_nxt  = ASCII_ZERO;
        zeros_nxt = zeros_r - LEN_W'(1);
      end else begin
        char_nxt = ASCII_ZERO + {2'b00, bcd_r[BCD_W-1 -: 4]};
        bcd_nxt  = {bcd_r[BCD_W-5:0], 4'd0};
        ndig_nxt = ndig_r - NDIG_W'(1);
      end
    end else begin
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    pad_r       <= pad_nxt;
    bcd_r       <= bcd_nxt;
    bit_cnt_r   <= bit_cnt_nxt;
    ndig_r      <= ndig_nxt;
    zeros_r     <= zeros_nxt;
    sign_pend_r <= sign_pend_nxt;
    char_r      <= char_nxt;
    last_r      <= last_nxt;
  end

  assign out_valid     = valid_r;
  assign out_char_code = char_r;
  assign out_last      = last_r;

endmodule

// File: rtl/core/sitda_ctrl.sv
`timescale 1ns / 1ps
// Controller FSM: sequences load, BCD conversion, leading-zero strip and
// character emission. Depends on sitda_pkg.
module sitda_ctrl import sitda_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_NORM = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        if (sts.conv_last) begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if (sts.norm_done) begin
          cmd.prep  = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      ST_EMIT: begin
        cmd.emit_step = 1'b1;
        if (sts.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// File: rtl/core/signed_int_to_decimal_ascii_top.sv
`timescale 1ns / 1ps
// Signed 64-bit integer to decimal ASCII text, one character word per
// out_valid strobe, most significant first; out_last marks the final word.
// A word is taken when start is high and busy is low. Each item passes
// through a load step, shift-add-3 conversion (one magnitude bit per cycle),
// stripping of leading zero digits (one digit per cycle), a step to set up
// sign and padding, then emission at one cycle per character (up to MAX_LEN,
// or the natural length if that is longer). busy drops in the cycle the last
// character appears, so the next word can follow at once.
// The receiver cannot stall: each character is on the out_ ports for
// exactly one cycle and must be captured then.
// Depends on sitda_pkg, sitda_ctrl, sitda_dp.
module signed_int_to_decimal_ascii_top import sitda_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [PAD_W-1:0]          in_pad_width,
  output logic                      out_valid,
  output logic [CHAR_W-1:0]         out_char_code,
  output logic                      out_last
);

  cmd_t cmd;
  sts_t sts;

  sitda_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  sitda_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_value      (in_value),
    .in_pad_width  (in_pad_width),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

endmodule

// File: tb/ascii_text_checker.sv
`timescale 1ns / 1ps
// Checker for the signed integer to decimal ASCII converter: watches the input and result
// words, predicts each number's text and compares it word by word.
// Depends on sitda_pkg.
module ascii_text_checker import sitda_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [PAD_W-1:0]          in_pad_width,
  input  logic                      out_valid,
  input  logic [CHAR_W-1:0]         out_char_code,
  input  logic                      out_last,
  output int                        fail_count,
  output int                        pending_words,
  output int                        words_checked,
  output int                        numbers_taken
);

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_word_t;

  text_word_t expected_text[$];
  int n_fail    = 0;
  int n_checked = 0;
  int n_numbers = 0;

  // sign first, then zero padding, then the digits, most significant first
  function automatic void queue_decimal_text(input logic [VALUE_W-1:0] v,
                                             input logic [PAD_W-1:0] pad);
    logic [VALUE_W-1:0] mag;
    logic [3:0]         digit [DIGITS];
    logic               neg;
    int                 ndig;
    int                 width;
    int                 n_zero;
    text_word_t         w;
    neg  = v[VALUE_W-1];
    mag  = neg ? (~v + 1'b1) : v;
    ndig = 0;
    do begin
      digit[ndig] = 4'(mag % 10);
      mag = mag / 10;
      ndig++;
    end while (mag != 0 && ndig < DIGITS);
    width  = (pad > MAX_LEN) ? MAX_LEN : int'(pad);
    n_zero = width - ndig - (neg ? 1 : 0);
    w.last = 1'b0;
    if (neg) begin
      w.code = ASCII_MINUS;
      expected_text.push_back(w);
    end
    for (int i = 0; i < n_zero; i++) begin
      w.code = ASCII_ZERO;
      expected_text.push_back(w);
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      w.code = ASCII_ZERO + digit[i];
      w.last = (i == 0);
      expected_text.push_back(w);
    end
  endfunction

  always @(posedge clk) begin : watch
    text_word_t w;
    if (!rst_n) begin
      expected_text.delete();
    end else begin
      // compare before taking a new word: a result in the accept cycle is older
      if (out_valid) begin
        if (expected_text.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected word: code %0d last %b", $time, out_char_code, out_last);
        end else begin
          w = expected_text.pop_front();
          n_checked++;
          if (out_char_code !== w.code || out_last !== w.last) begin
            n_fail++;
            $display("%0t: word mismatch: expected code %0d last %b, got code %0d last %b",
                     $time, w.code, w.last, out_char_code, out_last);
          end
        end
      end
      if (start && !busy) begin
        queue_decimal_text(in_value, in_pad_width);
        n_numbers++;
      end
    end
    fail_count    <= n_fail;
    pending_words <= expected_text.size();
    words_checked <= n_checked;
    numbers_taken <= n_numbers;
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the converter testbench: clock, reset, directed and random number stimulus
// with random idle cycles, and the verdict. Depends on sitda_pkg, the converter RTL
// and ascii_text_checker.
module testbench;
  import sitda_pkg::*;

  localparam int MAX_LEN     = MAX_LEN_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [VALUE_W-1:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] MOST_NEG = 64'h8000_0000_0000_0000;

  logic                      clk          = 1'b0;
  logic                      rst_n        = 1'b0;
  logic                      start        = 1'b0;
  logic signed [VALUE_W-1:0] in_value     = '0;
  logic [PAD_W-1:0]          in_pad_width = '0;
  logic                      busy;
  logic                      out_valid;
  logic [CHAR_W-1:0]         out_char_code;
  logic                      out_last;

  int fail_count;
  int pending_words;
  int words_checked;
  int numbers_taken;
  int cycles  = 0;
  bit idle_ok = 1'b1;

  always #2 clk = ~clk;

  signed_int_to_decimal_ascii_top #(.MAX_LEN(MAX_LEN)) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .in_pad_width  (in_pad_width),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

  ascii_text_checker #(.MAX_LEN(MAX_LEN)) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .in_pad_width  (in_pad_width),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last      (out_last),
    .fail_count    (fail_count),
    .pending_words (pending_words),
    .words_checked (words_checked),
    .numbers_taken (numbers_taken)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles, pending_words);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // offer the word until taken; idle cycles drop start and put junk on the fields
  task automatic send_number(input logic [VALUE_W-1:0] v, input logic [PAD_W-1:0] pad);
    bit offered;
    do begin
      offered = !(idle_ok && $urandom_range(99) < 34);
      if (offered) begin
        start        <= 1'b1;
        in_value     <= v;
        in_pad_width <= pad;
      end else begin
        start        <= 1'b0;
        in_value     <= {$urandom, $urandom};
        in_pad_width <= PAD_W'($urandom_range(63));
      end
      @(posedge clk);
    end while (!(offered && !busy));
  endtask

  // mix of full-range, small, n-digit, power-of-ten and extreme values
  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] lim;
    logic [VALUE_W-1:0] r;
    r   = {$urandom, $urandom};
    lim = VALUE_W'(1);
    case ($urandom_range(4))
      0: return r;
      1: r = VALUE_W'($urandom_range(99));
      2: begin
        repeat ($urandom_range(1, 19)) lim = lim * 10;
        r = r % lim;
      end
      3: begin
        repeat ($urandom_range(18)) lim = lim * 10;
        r = lim - VALUE_W'($urandom_range(1));
      end
      default: begin
        case ($urandom_range(3))
          0: return MOST_POS;
          1: return MOST_NEG;
          2: return MOST_NEG + 1;
          default: return MOST_POS - 1;
        endcase
      end
    endcase
    return $urandom_range(1) ? (~r + 1'b1) : r;
  endfunction

  initial begin
    logic [PAD_W-1:0] pad;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_number(0, 0);
    send_number(0, 63);
    send_number(5, 1);
    send_number(MOST_POS, 0);
    send_number(MOST_POS, 32);
    send_number(MOST_NEG, 0);
    send_number(MOST_NEG, 20);   // exactly natural length
    send_number(MOST_NEG, 32);
    send_number(MOST_NEG, 40);   // clamped
    send_number(-64'sd1, 0);
    send_number(-64'sd1, 5);
    send_number(64'sd1000000000000000000, 0);
    send_number(-64'sd999999999999999999, 21);
    send_number(42, 31);
    send_number(42, 32);
    send_number(42, 33);
    send_number(-64'sd42, 63);
    send_number(12345, 5);
    send_number(12345, 4);
    send_number(-64'sd12345, 6);
    send_number(-64'sd12345, 7);
    send_number(9, 2);
    send_number(10, 0);
    send_number(-64'sd10, 3);

    for (int i = 0; i < 460; i++) begin
      idle_ok = !(i >= 200 && i < 300);
      pad = ($urandom_range(3) == 0) ? PAD_W'($urandom_range(63)) : PAD_W'($urandom_range(24));
      send_number(random_value(), pad);
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d numbers converted (sign, padding, clamp and extreme cases, then random)",
             numbers_taken);
    $display("%0d character words checked, %0d failures", words_checked, fail_count);
    if (fail_count == 0 && pending_words == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/sitda_pkg.sv
rtl/core/sitda_dp.sv
rtl/core/sitda_ctrl.sv
rtl/core/signed_int_to_decimal_ascii_top.sv
tb/ascii_text_checker.sv
tb/testbench.sv
